// ===== design/pbs_pkg.sv =====
`default_nettype none

package pbs_pkg;

   localparam int TIME_W     = 32;
   localparam int BUF_SIZE_W = 7;

   localparam logic [TIME_W-1:0]     TIME_MAX     = {TIME_W{1'b1}};
   localparam logic [BUF_SIZE_W-1:0] BUF_SIZE_RST = BUF_SIZE_W'(64);

   typedef logic [TIME_W-1:0] time_type;

   // broadcast along the chain
   typedef struct packed {
      logic     shift;
      time_type wr_data;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ===== design/packet_buffer_scheduler.sv =====
// Packet buffer scheduler: a bounded buffer of finish times in front of one
// processor. Each input word carries an arrival time and a duration; each
// yields exactly one result word: dropped, or accepted with its start time.
// Input channel req_*: word taken when req_valid is high and req_stall low.
// Result channel rsp_*: word taken when rsp_valid is high and rsp_stall low.
// csr_wr_en / csr_wr_data set buffer_size (0 acts as 1, above DEPTH as DEPTH);
// write it only while the block is idle.
// rsp_valid rises in the cycle after acceptance; one word per cycle is
// sustained while rsp_stall is low. The rate is set by the feedback through
// the latest-finish register: compare with the head cell, max, saturating add.
// The buffer is a chain of DEPTH cells with the oldest entry in cell 0; on a
// retire every cell loads its upper neighbor, and the new entry is written at
// the fill position.
// While a result waits under rsp_stall, req_stall is raised and nothing is
// lost. Reset empties the buffer, clears the latest finish to 0 and sets
// buffer_size to 64; the cells keep their contents, with no clearing pass.
`default_nettype none

module packet_buffer_scheduler
   import pbs_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire  [TIME_W-1:0]     req_arrival_time,
   input  wire  [TIME_W-1:0]     req_duration,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output logic                  rsp_dropped,
   output logic [TIME_W-1:0]     rsp_start_time,
   input  wire                   csr_wr_en,
   input  wire  [BUF_SIZE_W-1:0] csr_wr_data
);

   localparam int OCC_W = $clog2(DEPTH + 1);

   logic [BUF_SIZE_W-1:0] buf_size_ff;
   logic [OCC_W-1:0]      occ_ff, occ_in;
   time_type              latest_ff, latest_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_dropped_ff;
   time_type              rsp_start_ff;

   time_type     cell_q [DEPTH];
   logic         cell_sel [DEPTH];
   cell_ctl_type ctl;

   logic [31:0]      cap;
   logic             full, drop, accept;
   time_type         start;
   logic [TIME_W:0]  sum;
   time_type         finish;
   logic [OCC_W-1:0] wr_pos;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      if (buf_size_ff == '0) begin
         cap = 32'd1;
      end else if (32'(buf_size_ff) > 32'(DEPTH)) begin
         cap = 32'(DEPTH);
      end else begin
         cap = 32'(buf_size_ff);
      end
   end

   assign full   = 32'(occ_ff) >= cap;
   assign drop   = full & (req_arrival_time < cell_q[0]);
   assign start  = (req_arrival_time > latest_ff) ? req_arrival_time : latest_ff;
   assign sum    = {1'b0, start} + {1'b0, req_duration};
   assign finish = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];

   assign ctl.shift   = accept & full & ~drop;
   assign ctl.wr_data = finish;
   assign wr_pos      = full ? (occ_ff - OCC_W'(1)) : occ_ff;

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         time_type upper;
         if (i == DEPTH - 1) begin : g_last
            assign upper = cell_q[i];
         end else begin : g_mid
            assign upper = cell_q[i+1];
         end
         assign cell_sel[i] = accept & ~drop & (wr_pos == OCC_W'(i));
         pbs_cell u_cell (
            .clock  (clock),
            .ctl    (ctl),
            .sel    (cell_sel[i]),
            .upper  (upper),
            .finish (cell_q[i])
         );
      end
   endgenerate

   always_comb begin
      occ_in    = occ_ff;
      latest_in = latest_ff;
      if (accept && !drop) begin
         latest_in = finish;
         if (!full) begin
            occ_in = occ_ff + OCC_W'(1);
         end
      end
   end

   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_size_ff  <= BUF_SIZE_RST;
         occ_ff       <= '0;
         latest_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            buf_size_ff <= csr_wr_data;
         end
         occ_ff       <= occ_in;
         latest_ff    <= latest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_dropped_ff <= drop;
         rsp_start_ff   <= drop ? '0 : start;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_dropped    = rsp_dropped_ff;
   assign rsp_start_time = rsp_start_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      32'(occ_ff) <= 32'(DEPTH))
      else $error("occupancy above depth");

   a_drop_keeps_occ: assert property (@(posedge clock) disable iff (reset)
      accept && drop |=> $stable(occ_ff) && $stable(latest_ff))
      else $error("drop changed buffer state");

   a_latest_grows: assert property (@(posedge clock) disable iff (reset)
      accept && !drop |=> latest_ff >= $past(start))
      else $error("latest finish below start");

   a_stall_only_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff)
      else $error("input stalled with no pending word");

   a_shift_only_full: assert property (@(posedge clock) disable iff (reset)
      ctl.shift |-> occ_ff != '0)
      else $error("retire from empty buffer");

endmodule

`default_nettype wire

// ===== design/pbs_cell.sv =====
`default_nettype none

module pbs_cell
   import pbs_pkg::*;
(
   input  wire               clock,
   input  wire cell_ctl_type ctl,
   input  wire               sel,
   input  wire time_type     upper,
   output time_type          finish
);

   time_type finish_ff;
   time_type finish_in;

   always_comb begin
      if (sel) begin
         finish_in = ctl.wr_data;
      end else if (ctl.shift) begin
         finish_in = upper;
      end else begin
         finish_in = finish_ff;
      end
   end

   always_ff @(posedge clock) begin
      finish_ff <= finish_in;
   end

   assign finish = finish_ff;

endmodule

`default_nettype wire
